[sv/tpd_pkg.sv]
// Shared types and constants of the tunnel PDU deframer.
// No dependencies; used by every module of the block by scoped names.
package tpd_pkg;

    localparam int unsigned FRAME_LEN_W = 17;
    localparam int unsigned ACTION_W    = 4;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [FRAME_LEN_W-1:0] MAX_FRAME_RESET = 17'd65790;
    localparam logic [ACTION_W-1:0]    ACTION_RESET    = 4'd2;
    localparam logic [7:0]             MIN_HEADER_LEN  = 8'd4;
    localparam logic [7:0]             MIN_SUB_LEN     = 8'd2;
    localparam logic [7:0]             MAX_SUB_TYPE    = 8'd1;

    localparam logic CFG_MAX_FRAME      = 1'b0;
    localparam logic CFG_HIGHEST_ACTION = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_SHORT    = 3'd1,
        ERR_OVERSIZE = 3'd2,
        ERR_ACTION   = 3'd3,
        ERR_SUBHDR   = 3'd4,
        ERR_EARLIER  = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] max_frame_bytes;
        logic [ACTION_W-1:0]    highest_action;
    } cfg_t;

    typedef struct packed {
        logic                data_valid;
        logic [7:0]          data_byte;
        logic                frame_end;
        logic [ACTION_W-1:0] frame_action;
        logic [7:0]          header_bytes;
        logic [15:0]         payload_bytes;
        err_code_t           error_code;
    } result_t;

endpackage

[sv/tpd_parser.sv]
// Frame parser of the tunnel PDU deframer: per-frame state registers and
// the single-pass next-state and result logic. Depends on tpd_pkg.
module tpd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  tpd_pkg::cfg_t    cfg,
    input  logic             in_fire,
    input  logic [7:0]       in_byte,
    output logic             res_valid,
    output tpd_pkg::result_t res
);

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    logic [tpd_pkg::FRAME_LEN_W-1:0] pos_reg, pos_next;
    logic [tpd_pkg::ACTION_W-1:0]    action_reg, action_next;
    logic [15:0]                     pay_len_reg, pay_len_next;
    logic [7:0]                      hdr_len_reg, hdr_len_next;
    logic [7:0]                      sub_rem_reg, sub_rem_next;
    phase_t                          phase_reg, phase_next;
    logic                            bad_action_reg, bad_action_next;
    logic                            bad_sub_reg, bad_sub_next;
    logic                            sticky_reg, sticky_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            action_reg     <= '0;
            pay_len_reg    <= '0;
            hdr_len_reg    <= '0;
            sub_rem_reg    <= '0;
            phase_reg      <= PH_LEN;
            bad_action_reg <= 1'b0;
            bad_sub_reg    <= 1'b0;
            sticky_reg     <= 1'b0;
        end else if (in_fire) begin
            pos_reg        <= pos_next;
            action_reg     <= action_next;
            pay_len_reg    <= pay_len_next;
            hdr_len_reg    <= hdr_len_next;
            sub_rem_reg    <= sub_rem_next;
            phase_reg      <= phase_next;
            bad_action_reg <= bad_action_next;
            bad_sub_reg    <= bad_sub_next;
            sticky_reg     <= sticky_next;
        end
    end

    always_comb begin
        logic [tpd_pkg::FRAME_LEN_W-1:0] total;
        logic [tpd_pkg::FRAME_LEN_W-1:0] pos_inc;
        logic [7:0]                      left;
        logic                            last;
        logic                            finish;
        logic                            fault;
        tpd_pkg::err_code_t              fault_code;

        pos_next        = pos_reg;
        action_next     = action_reg;
        pay_len_next    = pay_len_reg;
        hdr_len_next    = hdr_len_reg;
        sub_rem_next    = sub_rem_reg;
        phase_next      = phase_reg;
        bad_action_next = bad_action_reg;
        bad_sub_next    = bad_sub_reg;
        sticky_next     = sticky_reg;
        res_valid       = 1'b0;
        res             = '0;
        finish          = 1'b0;
        fault           = 1'b0;
        fault_code      = tpd_pkg::ERR_NONE;
        total           = '0;
        pos_inc         = pos_reg + 1'b1;
        left            = hdr_len_reg - pos_reg[7:0];
        last            = 1'b0;

        if (sticky_reg) begin
            res_valid        = 1'b1;
            res.error_code   = tpd_pkg::ERR_EARLIER;
        end else if (pos_reg == '0) begin
            action_next     = in_byte[3:0];
            hdr_len_next    = '0;
            pay_len_next    = '0;
            bad_action_next = (in_byte[7:4] != 4'd0) || (in_byte[3:0] > cfg.highest_action);
            bad_sub_next    = 1'b0;
            sub_rem_next    = '0;
            phase_next      = PH_LEN;
            pos_next        = pos_inc;
        end else if (pos_reg == 17'd1) begin
            pay_len_next = {8'd0, in_byte};
            pos_next     = pos_inc;
        end else if (pos_reg == 17'd2) begin
            pay_len_next = {in_byte, pay_len_reg[7:0]};
            pos_next     = pos_inc;
        end else if (pos_reg == 17'd3) begin
            hdr_len_next = in_byte;
            total        = {9'd0, in_byte} + {1'b0, pay_len_reg};
            if (in_byte < tpd_pkg::MIN_HEADER_LEN) begin
                fault      = 1'b1;
                fault_code = tpd_pkg::ERR_SHORT;
            end else if (total > cfg.max_frame_bytes) begin
                fault      = 1'b1;
                fault_code = tpd_pkg::ERR_OVERSIZE;
            end else if (total == 17'd4) begin
                finish = 1'b1;
            end else begin
                pos_next = pos_inc;
            end
        end else begin
            total = {9'd0, hdr_len_reg} + {1'b0, pay_len_reg};
            last  = (pos_inc == total);
            if (pos_reg < {9'd0, hdr_len_reg}) begin
                if (!bad_sub_reg) begin
                    case (phase_reg)
                        PH_LEN: begin
                            if (in_byte < tpd_pkg::MIN_SUB_LEN || in_byte > left) begin
                                bad_sub_next = 1'b1;
                            end else begin
                                sub_rem_next = in_byte - tpd_pkg::MIN_SUB_LEN;
                                phase_next   = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            if (in_byte > tpd_pkg::MAX_SUB_TYPE) begin
                                bad_sub_next = 1'b1;
                            end else begin
                                phase_next = (sub_rem_reg == 8'd0) ? PH_LEN : PH_BODY;
                            end
                        end
                        default: begin
                            if (sub_rem_reg != 8'd0) begin
                                sub_rem_next = sub_rem_reg - 8'd1;
                            end
                            if (sub_rem_reg <= 8'd1) begin
                                phase_next = PH_LEN;
                            end
                        end
                    endcase
                end
                if (last) begin
                    finish = 1'b1;
                end else begin
                    pos_next = pos_inc;
                end
            end else if (last) begin
                finish = 1'b1;
            end else begin
                pos_next = pos_inc;
                if (!bad_action_reg && !bad_sub_reg) begin
                    res_valid         = 1'b1;
                    res.data_valid    = 1'b1;
                    res.data_byte     = in_byte;
                    res.frame_action  = action_reg;
                    res.header_bytes  = hdr_len_reg;
                    res.payload_bytes = pay_len_reg;
                end
            end
        end

        if (finish) begin
            if (bad_action_next) begin
                fault      = 1'b1;
                fault_code = tpd_pkg::ERR_ACTION;
            end else if (bad_sub_next) begin
                fault      = 1'b1;
                fault_code = tpd_pkg::ERR_SUBHDR;
            end else begin
                res_valid     = 1'b1;
                res.frame_end = 1'b1;
                res.data_valid = (pos_reg >= {9'd0, hdr_len_reg}) && (pos_reg > 17'd3);
                res.data_byte  = res.data_valid ? in_byte : 8'd0;
                res.frame_action  = action_next;
                res.header_bytes  = hdr_len_next;
                res.payload_bytes = pay_len_next;
                pos_next     = '0;
                sub_rem_next = '0;
                phase_next   = PH_LEN;
            end
        end

        if (fault) begin
            res_valid         = 1'b1;
            res               = '0;
            res.frame_action  = action_next;
            res.header_bytes  = hdr_len_next;
            res.payload_bytes = pay_len_next;
            res.error_code    = fault_code;
            sticky_next       = 1'b1;
            pos_next          = '0;
            sub_rem_next      = '0;
            phase_next        = PH_LEN;
        end
    end

    a_sticky_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        sticky_reg |=> sticky_reg)
        else $error("sticky error cleared without reset");

    a_error_sets_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_valid && res.error_code != tpd_pkg::ERR_NONE) |=> sticky_reg)
        else $error("error result did not latch sticky error");

    a_sticky_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && sticky_reg) |-> (res_valid && res.error_code == tpd_pkg::ERR_EARLIER
                                     && !res.data_valid && !res.frame_end))
        else $error("item after an error not reported as earlier error");

    a_end_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && res_valid && res.frame_end) |=> (pos_reg == '0))
        else $error("frame end did not restart frame position");

endmodule

[sv/tpd_out_stage.sv]
// Result register with a skid stage for the tunnel PDU deframer.
// Parts the input handshake from the result handshake. Depends on tpd_pkg.
module tpd_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tpd_pkg::result_t push_data,
    output logic             in_ready,
    output logic             out_valid,
    output tpd_pkg::result_t out_data,
    input  logic             out_ready
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    tpd_pkg::result_t out_data_reg, out_data_next;
    tpd_pkg::result_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while result register is empty");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !push)
        else $error("item pushed while skid stage is full");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && out_data_reg == $past(skid_data_reg)))
        else $error("skid item not moved to result register");

endmodule

[sv/tunnel_pdu_deframer_core.sv]
// Top level of the tunnel PDU deframer: configuration registers, frame
// parser and result stage. Depends on tpd_pkg, tpd_parser, tpd_out_stage.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry the received tunnel stream, one byte per
//   item. Each frame is an action/flags byte, a little-endian payload length,
//   a header length, subheaders and payload. m_tvalid/m_tready/m_tdata carry
//   results: payload bytes of good frames (m_tuser high), frame summaries on
//   the last byte (m_tlast high), and error reports. Header bytes give no
//   result unless they end or fault the frame.
//   Each accepted byte's result is registered in the result stage for m_*.
//   Throughput is one byte per cycle while s_tready is high, set by the parser.
//   A two-entry result register and skid stage lets s_tready stay high while
//   one result waits; s_tready drops only once both entries hold results.
//   Reset (aresetn low, synchronous) clears the frame state, the sticky error
//   and both result entries and loads max_frame_bytes 65790, highest_action 2.
//   After any error every further byte gives error code 5 until reset.
//   cfg_wr_en writes cfg_wdata to register cfg_index at the clock edge;
//   write it only while the block is idle.
module tunnel_pdu_deframer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [tpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // in_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_byte[7:0], frame_action[11:8], header_bytes[19:12],
    // payload_bytes[35:20], error_code[38:36], zero[39]
    output logic [tpd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tlast,   // frame_end
    output logic                             m_tuser    // data_valid
);

    tpd_pkg::cfg_t    cfg_reg;
    logic             in_fire;
    logic             res_valid;
    tpd_pkg::result_t res;
    tpd_pkg::result_t out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frame_bytes <= tpd_pkg::MAX_FRAME_RESET;
            cfg_reg.highest_action  <= tpd_pkg::ACTION_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tpd_pkg::CFG_MAX_FRAME:      cfg_reg.max_frame_bytes <= cfg_wdata;
                tpd_pkg::CFG_HIGHEST_ACTION: cfg_reg.highest_action  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign in_fire = s_tvalid && s_tready;

    tpd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    tpd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire && res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {1'b0, out_res.error_code, out_res.payload_bytes, out_res.header_bytes,
                      out_res.frame_action, out_res.data_byte};
    assign m_tlast = out_res.frame_end;
    assign m_tuser = out_res.data_valid;

endmodule

[tb/tunnel_pdu_deframer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for tunnel_pdu_deframer_core: drives tunnel PDU byte streams,
// predicts every result with a local deframer model and compares on m_*.
// Depends on tpd_pkg and the core RTL.
module tunnel_pdu_deframer_core_tb;

    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RANDOM_BYTES  = 850;
    localparam int unsigned BAD_ACT       = 0;
    localparam int unsigned BAD_SUB       = 1;

    typedef enum logic [1:0] {
        WALK_LEN,
        WALK_TYPE,
        WALK_BODY
    } walk_phase_t;

    typedef enum int {
        BREAK_SHORT,
        BREAK_OVERSIZE,
        BREAK_ACTION,
        BREAK_SUBHDR
    } break_kind_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic                            cfg_index;
    logic [tpd_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tpd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;

    tunnel_pdu_deframer_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // deframer model state and register copies
    logic [tpd_pkg::FRAME_LEN_W-1:0] cfg_max_frame;
    logic [tpd_pkg::ACTION_W-1:0]    cfg_top_action;
    logic [16:0]                     frame_pos;
    logic [7:0]                      act_flags;
    logic [15:0]                     pay_len;
    logic [7:0]                      hdr_len;
    logic [7:0]                      sub_left;
    walk_phase_t                     walk_phase;
    logic [1:0]                      hdr_fault;
    logic                            err_latched;

    tpd_pkg::result_t expected_q[$];
    tpd_pkg::result_t exp_r;
    int unsigned      mismatches = 0;
    int unsigned      bytes_sent = 0;
    int unsigned      cycles = 0;
    int               rx_hold = 0;
    bit               tx_gaps = 1'b1;
    bit               rx_gaps = 1'b1;

    function automatic void reset_model();
        cfg_max_frame  = tpd_pkg::MAX_FRAME_RESET;
        cfg_top_action = tpd_pkg::ACTION_RESET;
        frame_pos      = '0;
        act_flags      = '0;
        pay_len        = '0;
        hdr_len        = '0;
        sub_left       = '0;
        walk_phase     = WALK_LEN;
        hdr_fault      = '0;
        err_latched    = 1'b0;
    endfunction

    function automatic void restart_frame();
        frame_pos  = '0;
        sub_left   = '0;
        walk_phase = WALK_LEN;
    endfunction

    function automatic tpd_pkg::result_t frame_summary();
        tpd_pkg::result_t r;
        r = '0;
        r.frame_action  = act_flags[3:0];
        r.header_bytes  = hdr_len;
        r.payload_bytes = pay_len;
        return r;
    endfunction

    function automatic tpd_pkg::result_t flag_error(input tpd_pkg::err_code_t code);
        tpd_pkg::result_t r;
        r = frame_summary();
        r.error_code = code;
        err_latched = 1'b1;
        restart_frame();
        return r;
    endfunction

    function automatic tpd_pkg::result_t close_frame();
        tpd_pkg::result_t r;
        if (hdr_fault[BAD_ACT])
            return flag_error(tpd_pkg::ERR_ACTION);
        if (hdr_fault[BAD_SUB])
            return flag_error(tpd_pkg::ERR_SUBHDR);
        r = frame_summary();
        r.frame_end  = 1'b1;
        r.error_code = tpd_pkg::ERR_NONE;
        restart_frame();
        return r;
    endfunction

    function automatic void walk_subheader(input logic [7:0] b, input int unsigned pos);
        int unsigned room;
        room = hdr_len - pos;
        if (hdr_fault[BAD_SUB])
            return;
        case (walk_phase)
            WALK_LEN: begin
                if (b < tpd_pkg::MIN_SUB_LEN || b > room) begin
                    hdr_fault[BAD_SUB] = 1'b1;
                end else begin
                    sub_left   = b - tpd_pkg::MIN_SUB_LEN;
                    walk_phase = WALK_TYPE;
                end
            end
            WALK_TYPE: begin
                if (b > tpd_pkg::MAX_SUB_TYPE)
                    hdr_fault[BAD_SUB] = 1'b1;
                else
                    walk_phase = (sub_left == 0) ? WALK_LEN : WALK_BODY;
            end
            default: begin
                if (sub_left > 0)
                    sub_left--;
                if (sub_left == 0)
                    walk_phase = WALK_LEN;
            end
        endcase
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output tpd_pkg::result_t r);
        int unsigned pos;
        int unsigned total;
        r = '0;
        if (err_latched) begin
            r.error_code = tpd_pkg::ERR_EARLIER;
            return 1'b1;
        end
        pos = frame_pos;
        if (pos == 0) begin
            act_flags = b;
            hdr_len = '0;
            pay_len = '0;
            hdr_fault = '0;
            hdr_fault[BAD_ACT] = (b[7:4] != 0) || (b[3:0] > cfg_top_action);
            sub_left = '0;
            walk_phase = WALK_LEN;
            frame_pos = 17'd1;
            return 1'b0;
        end
        if (pos == 1) begin
            pay_len = {8'h00, b};
            frame_pos = 17'd2;
            return 1'b0;
        end
        if (pos == 2) begin
            pay_len[15:8] = b;
            frame_pos = 17'd3;
            return 1'b0;
        end
        if (pos == 3) begin
            hdr_len = b;
            if (b < tpd_pkg::MIN_HEADER_LEN) begin
                r = flag_error(tpd_pkg::ERR_SHORT);
                return 1'b1;
            end
            total = b + pay_len;
            if (total > cfg_max_frame) begin
                r = flag_error(tpd_pkg::ERR_OVERSIZE);
                return 1'b1;
            end
            if (total == tpd_pkg::MIN_HEADER_LEN) begin
                r = close_frame();
                return 1'b1;
            end
            frame_pos = 17'd4;
            return 1'b0;
        end
        total = hdr_len + pay_len;
        if (pos < hdr_len) begin
            walk_subheader(b, pos);
            if (pos + 1 >= total) begin
                r = close_frame();
                return 1'b1;
            end
            frame_pos = 17'(pos + 1);
            return 1'b0;
        end
        if (pos + 1 >= total) begin
            r = close_frame();
            if (hdr_fault == 0) begin
                r.data_valid = 1'b1;
                r.data_byte  = b;
            end
            return 1'b1;
        end
        frame_pos = 17'(pos + 1);
        if (hdr_fault != 0)
            return 1'b0;
        r = frame_summary();
        r.data_valid = 1'b1;
        r.data_byte  = b;
        return 1'b1;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (rx_hold > 0) begin
                repeat (rx_hold) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
                rx_hold = 0;
            end
            stall = rx_gaps ? $urandom_range(0, 3) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("result item with none expected: tdata %h", m_tdata);
                mismatches++;
            end else begin
                exp_r = expected_q.pop_front();
                check_field("data_valid", exp_r.data_valid, m_tuser);
                check_field("data_byte", exp_r.data_byte, m_tdata[7:0]);
                check_field("frame_end", exp_r.frame_end, m_tlast);
                check_field("frame_action", exp_r.frame_action, m_tdata[11:8]);
                check_field("header_bytes", exp_r.header_bytes, m_tdata[19:12]);
                check_field("payload_bytes", exp_r.payload_bytes, m_tdata[35:20]);
                check_field("error_code", exp_r.error_code, m_tdata[38:36]);
                check_field("tdata_pad", 0, m_tdata[39]);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int               gap;
        tpd_pkg::result_t r;
        gap = tx_gaps ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        if (deframe_byte(b, r))
            expected_q.push_back(r);
        bytes_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_register(input logic idx,
                                 input logic [tpd_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == tpd_pkg::CFG_MAX_FRAME)
            cfg_max_frame = val;
        else
            cfg_top_action = val[tpd_pkg::ACTION_W-1:0];
    endtask

    // header, subheader walk of hlen-4 bytes, then random payload
    task automatic send_frame(input logic [7:0] act_b, input int hlen, input int plen,
                              input bit corrupt_sub);
        int         room;
        int         len;
        int         k;
        logic [7:0] len_b;
        logic [7:0] typ_b;
        bit         first;
        send_byte(act_b);
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
        send_byte(hlen[7:0]);
        room  = hlen - 4;
        first = 1'b1;
        while (room > 0) begin
            len = (room == 1) ? 1 : $urandom_range(2, (room < 40) ? room : 40);
            if ($urandom_range(0, 15) == 0 || room - len == 1)
                len = room;
            len_b = len[7:0];
            typ_b = 8'($urandom_range(0, 1));
            if (corrupt_sub && first) begin
                case ($urandom_range(0, 2))
                    0: len_b = 8'($urandom_range(0, 1));
                    1: len_b = 8'($urandom_range(room + 1, 255));
                    default: typ_b = 8'($urandom_range(2, 255));
                endcase
            end
            first = 1'b0;
            for (k = 0; k < len; k++)
                send_byte((k == 0) ? len_b : (k == 1) ? typ_b : 8'($urandom_range(0, 255)));
            room -= len;
        end
        for (k = 0; k < plen; k++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_default_frames();
        send_frame(8'h00, tpd_pkg::MIN_HEADER_LEN, 0, 1'b0);
        send_frame(8'(tpd_pkg::ACTION_RESET), 6, 2, 1'b0);
        send_byte(8'h01);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(tpd_pkg::MIN_HEADER_LEN);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h5a);
        send_frame(8'h01, 8, 0, 1'b0);
    endtask

    task automatic test_largest_frame();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_frame(8'h02, 255, 256, 1'b0);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    task automatic test_register_extremes();
        load_register(tpd_pkg::CFG_MAX_FRAME, 17'(tpd_pkg::MIN_HEADER_LEN));
        load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'd0);
        repeat (4) send_frame(8'h00, tpd_pkg::MIN_HEADER_LEN, 0, 1'b0);
        load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'd15);
        send_frame(8'h0f, tpd_pkg::MIN_HEADER_LEN, 0, 1'b0);
        repeat (6) send_frame(8'($urandom_range(0, 15)), tpd_pkg::MIN_HEADER_LEN, 0, 1'b0);
        load_register(tpd_pkg::CFG_MAX_FRAME, 17'd20);
        send_frame(8'h0f, 8, 12, 1'b0);
        load_register(tpd_pkg::CFG_MAX_FRAME, tpd_pkg::MAX_FRAME_RESET);
        load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'(tpd_pkg::ACTION_RESET));
    endtask

    task automatic test_output_backpressure();
        rx_hold = 300;
        send_frame(8'h00, tpd_pkg::MIN_HEADER_LEN, 200, 1'b0);
    endtask

    task automatic test_sender_pause();
        send_frame(8'h01, 10, 5, 1'b0);
        send_frame(8'h02, tpd_pkg::MIN_HEADER_LEN, 3, 1'b0);
        drain_results();
        send_frame(8'h00, 6, 4, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        int unsigned next_cfg;
        int          mx;
        int          cap;
        int          hlen;
        int          plen;
        int          room;
        stop_at  = bytes_sent + RANDOM_BYTES;
        next_cfg = bytes_sent;
        while (bytes_sent < stop_at) begin
            if (bytes_sent >= next_cfg) begin
                case ($urandom_range(0, 3))
                    0: mx = tpd_pkg::MIN_HEADER_LEN;
                    1: mx = tpd_pkg::MAX_FRAME_RESET;
                    2: mx = $urandom_range(6, 120);
                    default: mx = $urandom_range(tpd_pkg::MIN_HEADER_LEN,
                                                 tpd_pkg::MAX_FRAME_RESET);
                endcase
                load_register(tpd_pkg::CFG_MAX_FRAME, 17'(mx));
                case ($urandom_range(0, 3))
                    0: load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'd0);
                    1: load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'd15);
                    default: load_register(tpd_pkg::CFG_HIGHEST_ACTION,
                                           17'($urandom_range(0, 15)));
                endcase
                tx_gaps  = ($urandom_range(0, 3) != 0);
                rx_gaps  = ($urandom_range(0, 3) != 0);
                next_cfg = bytes_sent + $urandom_range(150, 350);
            end
            cap  = cfg_max_frame;
            hlen = $urandom_range(tpd_pkg::MIN_HEADER_LEN, (cap < 40) ? cap : 40);
            if (cap >= 255 && $urandom_range(0, 40) == 0)
                hlen = $urandom_range(200, 255);
            if (hlen == 5)
                hlen = tpd_pkg::MIN_HEADER_LEN;
            room = cap - hlen;
            plen = $urandom_range(0, (room < 48) ? room : 48);
            if (room >= 1000 && $urandom_range(0, 60) == 0)
                plen = $urandom_range(300, 1000);
            send_frame(8'($urandom_range(0, cfg_top_action)), hlen, plen, 1'b0);
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    // errors latch until reset, so one broken frame ends the run
    task automatic test_sticky_error();
        break_kind_t kind;
        int          mx;
        int          hlen;
        int          plen;
        int          top;
        kind = break_kind_t'($urandom_range(0, 3));
        load_register(tpd_pkg::CFG_MAX_FRAME, tpd_pkg::MAX_FRAME_RESET);
        case (kind)
            BREAK_SHORT: begin
                send_byte(8'h00);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, tpd_pkg::MIN_HEADER_LEN - 1)));
            end
            BREAK_OVERSIZE: begin
                mx = $urandom_range(tpd_pkg::MIN_HEADER_LEN, 2000);
                load_register(tpd_pkg::CFG_MAX_FRAME, 17'(mx));
                hlen = $urandom_range(tpd_pkg::MIN_HEADER_LEN, (mx < 255) ? mx : 255);
                plen = mx - hlen + $urandom_range(1, 100);
                send_byte(8'h00);
                send_byte(plen[7:0]);
                send_byte(plen[15:8]);
                send_byte(hlen[7:0]);
            end
            BREAK_ACTION: begin
                top = $urandom_range(0, 14);
                load_register(tpd_pkg::CFG_HIGHEST_ACTION, 17'(top));
                if ($urandom_range(0, 1))
                    send_frame({4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))},
                               $urandom_range(6, 12), $urandom_range(0, 10), 1'b0);
                else
                    send_frame(8'($urandom_range(top + 1, 15)), $urandom_range(6, 12),
                               $urandom_range(0, 10), 1'b0);
            end
            default: begin
                send_frame(8'h00, $urandom_range(6, 30), $urandom_range(0, 10), 1'b1);
            end
        endcase
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        reset_model();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_default_frames();
        test_largest_frame();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_frames();
        test_sticky_error();
        drain_results();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/tpd_pkg.sv
sv/tpd_parser.sv
sv/tpd_out_stage.sv
sv/tunnel_pdu_deframer_core.sv
tb/tunnel_pdu_deframer_core_tb.sv
